### rtl/scds_pkg.sv
package scds_pkg;

   localparam int TARGET_W     = 32;
   localparam int FIRST_DIV_W  = 2;
   localparam int SECOND_DIV_W = 6;
   localparam int RATE_W       = 32;
   localparam int BASE_DIV     = 22;
   localparam int NUM_A_DEF    = 4;
   localparam int NUM_B_DEF    = 64;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [31:0] INPUT_CLOCK_HZ_RESET = 32'd100_000_000;

   // register index, taken from paddr[2]
   typedef enum logic [0:0] {
      CSR_INPUT_CLOCK_HZ = 1'b0
   } csr_index_type;

endpackage

### rtl/scl_clock_divider_search_unit.sv
// Serial clock divider search.
// A request on req_ carries a wanted serial clock rate; against the input clock
// rate held in the csr_ register it returns on rsp_ the divider pair (a, b) with
// f = clk / (22 * (a+1) * (b+1)) that comes closest to the target from below.
// rsp_tuser flags a request that fails the coarse ratio check; the divider and
// rate fields are then zero. When no pair fits, a = b = 0 and the rate is the
// target.
// The pipeline length comes from the per-lane ceiling division for b (one
// quotient bit per stage) and the 32-stage restoring divider that forms the
// achieved rate.
// Throughput: one request per cycle unless rsp_tready stalls the output; all
// NUM_A first-stage values are tried in parallel lanes.
// Reset empties the pipeline and the output register and loads the input clock
// register with 100 MHz. While rsp_tready is low and a result waits, the whole
// pipeline holds, so nothing is lost or repeated; req_tready falls with it.
// The user must write the input clock register only while no request is in
// flight; the block itself does not enforce this.
module scl_clock_divider_search_unit #(
   parameter int NUM_A = scds_pkg::NUM_A_DEF,
   parameter int NUM_B = scds_pkg::NUM_B_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [scds_pkg::TARGET_W-1:0]     req_tdata,   // [31:0] target_rate
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] first_divider, [7:2] second_divider, [39:8] achieved_rate
   output logic [39:0]                       rsp_tdata,
   output logic [0:0]                        rsp_tuser,   // [0] invalid
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [scds_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import scds_pkg::*;

   localparam int TW   = TARGET_W;
   localparam int PW   = TW + 5;
   localparam int NAB1 = NUM_A * NUM_B + 1;
   localparam int XW   = PW + $clog2(NAB1 + 1);
   localparam int DW   = TW + $clog2(BASE_DIV * NUM_A + 1);
   localparam int QB   = $clog2(NUM_B) + 1;
   localparam int SW   = DW + QB;
   localparam int MW   = $clog2(BASE_DIV * NUM_A * NUM_B + 1);
   localparam int PRW  = TW + MW;
   localparam int AW   = (NUM_A > 1) ? $clog2(NUM_A) : 1;
   localparam int ST_D = 3 + QB;
   localparam int ST_M = 4 + QB;
   localparam int ST_H = 37 + QB;
   localparam int NST  = 38 + QB;

   typedef struct packed {
      logic                          inv;
      logic [TW-1:0]                 tgt;
      logic [PW-1:0]                 p;
      logic [NUM_A-1:0]              lok;
      logic [NUM_A-1:0][TW-1:0]      rem;
      logic [NUM_A-1:0][DW-1:0]      den;
      logic [NUM_A-1:0][QB-1:0]      q;
      logic [NUM_A-1:0][MW-1:0]      d;
      logic                          any;
      logic [MW-1:0]                 dmin;
      logic [MW-1:0]                 rrem;
      logic [TW-1:0]                 rq;
      logic [NUM_A-1:0]              hit;
   } item_type;

   logic [31:0]      clk_ff;
   logic             en;
   logic [NST-1:0]   v_ff;
   item_type         pipe_ff [NST];
   item_type         stage_in [NST];
   logic             rsp_valid_ff;
   logic [39:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_inv_ff, rsp_inv_in;

   // configuration port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff <= INPUT_CLOCK_HZ_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_index_type'(csr_paddr[2]) == CSR_INPUT_CLOCK_HZ) begin
         clk_ff <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index_type'(csr_paddr[2]))
         CSR_INPUT_CLOCK_HZ: csr_prdata = clk_ff;
         default:            csr_prdata = '0;
      endcase
   end

   // whole pipeline moves together; output register parts the two sides
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   for (genvar s = 0; s < NST; s++) begin : g_stage
      if (s == 0) begin : g_capture
         always_comb begin
            stage_in[s]     = '0;
            stage_in[s].tgt = req_tdata;
         end
      end else if (s == 1) begin : g_scale
         always_comb begin
            stage_in[s]   = pipe_ff[s-1];
            stage_in[s].p = PW'(pipe_ff[s-1].tgt) * PW'(BASE_DIV);
         end
      end else if (s == 2) begin : g_ratio
         always_comb begin
            logic [XW-1:0] lim;
            lim         = XW'(pipe_ff[s-1].p) * XW'(NAB1);
            stage_in[s] = pipe_ff[s-1];
            // coarse ratio must lie in 1 .. NUM_A*NUM_B
            stage_in[s].inv = (pipe_ff[s-1].tgt == '0) ||
                              (PW'(clk_ff) < pipe_ff[s-1].p) ||
                              (XW'(clk_ff) >= lim);
            for (int i = 0; i < NUM_A; i++) begin
               stage_in[s].den[i] = DW'(pipe_ff[s-1].p) * DW'(i + 1);
               stage_in[s].rem[i] = clk_ff - 32'd1;
            end
         end
      end else if (s < ST_D) begin : g_bdiv
         localparam int K = QB - 1 - (s - 3);
         always_comb begin
            logic [SW-1:0] shifted;
            stage_in[s] = pipe_ff[s-1];
            for (int i = 0; i < NUM_A; i++) begin
               shifted = SW'(pipe_ff[s-1].den[i]) << K;
               // quotient of (clk-1)/den must fit in QB bits
               if (s == 3) begin
                  stage_in[s].lok[i] = SW'(pipe_ff[s-1].rem[i]) <
                                       (SW'(pipe_ff[s-1].den[i]) << QB);
               end
               if (SW'(pipe_ff[s-1].rem[i]) >= shifted) begin
                  stage_in[s].rem[i]  = pipe_ff[s-1].rem[i] - TW'(shifted);
                  stage_in[s].q[i][K] = 1'b1;
               end
            end
         end
      end else if (s == ST_D) begin : g_total
         always_comb begin
            stage_in[s] = pipe_ff[s-1];
            for (int i = 0; i < NUM_A; i++) begin
               // b = q, divider total 22*(a+1)*(b+1)
               stage_in[s].d[i]   = MW'(BASE_DIV * (i + 1)) *
                                    (MW'(pipe_ff[s-1].q[i]) + MW'(1));
               stage_in[s].lok[i] = pipe_ff[s-1].lok[i] &&
                                    (pipe_ff[s-1].q[i] <= QB'(NUM_B - 1));
            end
         end
      end else if (s == ST_M) begin : g_min
         always_comb begin
            stage_in[s]      = pipe_ff[s-1];
            stage_in[s].any  = 1'b0;
            stage_in[s].dmin = '1;
            stage_in[s].rrem = '0;
            stage_in[s].rq   = '0;
            for (int i = 0; i < NUM_A; i++) begin
               if (pipe_ff[s-1].lok[i] && pipe_ff[s-1].d[i] < stage_in[s].dmin) begin
                  stage_in[s].dmin = pipe_ff[s-1].d[i];
               end
               stage_in[s].any = stage_in[s].any | pipe_ff[s-1].lok[i];
            end
         end
      end else if (s < ST_H) begin : g_rdiv
         localparam int K = TW - 1 - (s - ST_M - 1);
         always_comb begin
            logic [MW:0] r;
            stage_in[s] = pipe_ff[s-1];
            r = {pipe_ff[s-1].rrem, clk_ff[K]};
            if (r >= {1'b0, pipe_ff[s-1].dmin}) begin
               stage_in[s].rrem  = MW'(r - {1'b0, pipe_ff[s-1].dmin});
               stage_in[s].rq[K] = 1'b1;
            end else begin
               stage_in[s].rrem = MW'(r);
            end
         end
      end else begin : g_hit
         // a lane reaches the best rate when rate * its divider still fits in clk
         always_comb begin
            stage_in[s] = pipe_ff[s-1];
            for (int i = 0; i < NUM_A; i++) begin
               stage_in[s].hit[i] = pipe_ff[s-1].lok[i] &&
                  (PRW'(pipe_ff[s-1].rq) * PRW'(pipe_ff[s-1].d[i]) <= PRW'(clk_ff));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pipe_ff[s] <= stage_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], req_tvalid};
      end
   end

   // first lane that hits wins ties
   always_comb begin
      logic [AW-1:0] sel;
      item_type      n;
      n   = pipe_ff[NST-1];
      sel = '0;
      for (int i = NUM_A - 1; i >= 0; i--) begin
         if (n.hit[i]) begin
            sel = AW'(i);
         end
      end
      rsp_inv_in = n.inv;
      if (n.inv) begin
         rsp_data_in = '0;
      end else if (!n.any) begin
         rsp_data_in = {n.tgt, 6'd0, 2'd0};
      end else begin
         rsp_data_in = {RATE_W'(n.rq), SECOND_DIV_W'(n.q[sel]), FIRST_DIV_W'(sel)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_inv_ff  <= rsp_inv_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_inv_ff;

   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("invalid request with nonzero divider fields");

   a_hit_found: assert property (@(posedge clock) disable iff (reset)
      v_ff[NST-1] && !pipe_ff[NST-1].inv && pipe_ff[NST-1].any
      |-> pipe_ff[NST-1].hit != '0)
      else $error("fitting lane found but no lane reaches the best rate");

   a_dmin_set: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_M] && pipe_ff[ST_M].any |-> pipe_ff[ST_M].dmin != '0)
      else $error("smallest divider total is zero");

endmodule

### verif/testbench.sv
module testbench;
   import scds_pkg::*;

   localparam int HOLD_LIMIT = 5000;
   localparam int DRAIN_GAP  = 60;

   typedef struct packed {
      logic        invalid;
      logic [1:0]  first_div;
      logic [5:0]  second_div;
      logic [31:0] rate;
   } divider_choice_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   divider_choice_type pending_choices[$];
   logic [31:0] clock_hz_copy = INPUT_CLOCK_HZ_RESET;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          holdoff_cycles = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   scl_clock_divider_search_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic divider_choice_type search_dividers(logic [31:0] clk_hz,
                                                          logic [31:0] tgt);
      divider_choice_type res;
      logic [63:0] clk, t, ratio, den, nb, rate, err, best_err;
      bit found;
      clk = clk_hz;
      t = tgt;
      res = '0;
      found = 0;
      best_err = 0;
      if (t == 0) begin
         res.invalid = 1'b1;
         return res;
      end
      ratio = clk / (64'd22 * t);
      if (ratio == 0 || ratio > 64'd256) begin
         res.invalid = 1'b1;
         return res;
      end
      res.rate = tgt;
      for (int a = 0; a < 4; a++) begin
         den = 64'd22 * t * (a + 1);
         nb = (clk + den - 1) / den;
         if (nb < 1 || nb > 64) continue;
         rate = clk / (64'd22 * (a + 1) * nb);
         if (rate > t) continue;
         err = t - rate;
         if (!found || err < best_err) begin
            found = 1;
            best_err = err;
            res.first_div = a[1:0];
            res.second_div = 6'(nb - 1);
            res.rate = rate[31:0];
         end
      end
      return res;
   endfunction

   // mostly targets near the valid ratio window, some anywhere
   function automatic logic [31:0] pick_target();
      logic [63:0] t;
      if ($urandom_range(0, 99) < 80) begin
         t = clock_hz_copy / (64'd22 * $urandom_range(1, 260));
         t = t + $urandom_range(0, 2);
         t = (t > 1) ? t - 1 : 64'd1;
      end else begin
         t = $urandom;
      end
      if (t == 0) t = 1;
      return t[31:0];
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (holdoff_cycles > 0) begin
            rsp_tready <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      divider_choice_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata[1:0], rsp_tdata[7:2], rsp_tdata[39:8]};
         if (pending_choices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_choices.pop_front();
            if (got.invalid !== want.invalid || got.first_div !== want.first_div ||
                got.second_div !== want.second_div || got.rate !== want.rate) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HOLD_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_target(logic [31:0] tgt);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= tgt;
      do @(posedge clock); while (!req_tready);
      pending_choices.push_back(search_dividers(clock_hz_copy, tgt));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending_choices.size() == 0);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_clock_hz(logic [31:0] hz);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(CSR_INPUT_CLOCK_HZ) << 2;
      csr_pwdata <= hz;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      clock_hz_copy = hz;
      @(posedge clock);
   endtask

   task automatic test_directed();
      logic [63:0] t;
      int ratios[3] = '{1, 256, 257};
      send_target(32'd1);
      send_target(32'hFFFF_FFFF);
      send_target(32'd100_000);
      send_target(32'd400_000);
      send_target(32'd1_000_000);
      // ratio 256 that is not exact: no pair fits
      send_target(32'd17_750);
      foreach (ratios[i]) begin
         t = clock_hz_copy / (64'd22 * ratios[i]);
         for (int d = -1; d <= 1; d++)
            if (t + d > 0) send_target(32'(t + d));
      end
      drain();
   endtask

   task automatic test_random(int n, int idle_pct, int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (n) send_target(pick_target());
   endtask

   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      holdoff_cycles = 400;
      repeat (120) send_target(pick_target());
      // pause until every result is back
      drain();
      repeat (20) send_target(pick_target());
   endtask

   task automatic test_clock_setting(logic [31:0] hz, int n);
      write_clock_hz(hz);
      test_directed();
      test_random(n / 4, 0, 0);
      test_random(n / 4, 49, 0);
      test_random(n / 4, 0, 49);
      test_random(n / 4, 14, 14);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400, 0, 0);
      test_random(100, 49, 0);
      test_random(100, 0, 49);
      test_random(100, 14, 14);
      test_backpressure();
      test_clock_setting(32'hFFFF_FFFF, 240);
      test_clock_setting(32'd0, 40);
      test_clock_setting(32'd22, 40);
      test_clock_setting($urandom, 240);
      test_clock_setting(32'd12_345_678, 120);
      drain();
      if (mismatches == 0 && pending_choices.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
